// ===== hw/rtl/bdcd_pkg.sv =====
// Shared types and constants for the button double-click detector.
// No dependencies; used by bdcd_lane, bdcd_merge and the top level.
package bdcd_pkg;

  localparam int NumButtons = 16;
  localparam int LevelBits  = 16;
  localparam int MaskBits   = 16;
  localparam int TimeW      = 31;
  localparam int WinW       = 8;
  localparam int ActW       = 5;
  localparam int InDataW    = 48;
  localparam int OutDataW   = 40;
  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = 32;

  localparam logic [TimeW-1:0] TimeMax   = {TimeW{1'b1}};
  localparam logic [WinW-1:0]  WinReset  = 8'd1;
  localparam logic [ActW-1:0]  ActReset  = 5'd16;

  // Register index, taken from paddr[2]
  typedef enum logic [0:0] {
    RegWindow = 1'b0,
    RegActive = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CntNone = 2'd0,
    CntOne  = 2'd1,
    CntTwo  = 2'd2
  } click_cnt_t;

  // Per-sample control broadcast to every lane
  typedef struct packed {
    logic             take;
    logic [TimeW-1:0] now;
    logic [WinW-1:0]  win;
  } lane_ctl_t;

  // What one lane found for the current sample
  typedef struct packed {
    logic held;
    logic dbl;
  } lane_res_t;

endpackage

// ===== hw/rtl/bdcd_lane.sv =====
// One button lane: press latch, click count and deadline, plus next-state logic.
// Depends on bdcd_pkg.
module bdcd_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bdcd_pkg::lane_ctl_t  ctl,
  input  logic                 active,
  input  logic                 level,
  output bdcd_pkg::lane_res_t  res
);

  logic                          latch_r, latch_nxt;
  bdcd_pkg::click_cnt_t          count_r, count_nxt;
  logic [bdcd_pkg::TimeW-1:0]    deadline_r, deadline_nxt;
  logic [bdcd_pkg::TimeW:0]      sum;
  logic [bdcd_pkg::TimeW-1:0]    deadline_new;
  logic                          flag;

  // Saturate the new deadline at the top of the time range
  assign sum          = {1'b0, ctl.now} + {{(bdcd_pkg::TimeW + 1 - bdcd_pkg::WinW){1'b0}}, ctl.win};
  assign deadline_new = sum[bdcd_pkg::TimeW] ? bdcd_pkg::TimeMax : sum[bdcd_pkg::TimeW-1:0];

  always_comb begin
    latch_nxt    = latch_r;
    count_nxt    = count_r;
    deadline_nxt = deadline_r;
    flag         = 1'b0;
    if (level) begin
      if (!latch_r) begin
        latch_nxt = 1'b1;
        if (count_r == bdcd_pkg::CntNone || ctl.now > deadline_r) begin
          deadline_nxt = deadline_new;
          count_nxt    = bdcd_pkg::CntOne;
        end else if (ctl.now < deadline_r) begin
          flag         = 1'b1;
          deadline_nxt = '0;
          count_nxt    = bdcd_pkg::CntTwo;
        end
      end else if (count_r == bdcd_pkg::CntTwo) begin
        flag = 1'b1;
      end
    end else begin
      if (count_r == bdcd_pkg::CntTwo) begin
        count_nxt = bdcd_pkg::CntNone;
      end
      latch_nxt = 1'b0;
    end
  end

  assign res.held = active & level;
  assign res.dbl  = active & flag;

  // Inactive lanes hold their state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r    <= 1'b0;
      count_r    <= bdcd_pkg::CntNone;
      deadline_r <= '0;
    end else if (ctl.take && active) begin
      latch_r    <= latch_nxt;
      count_r    <= count_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  a_two_clears_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == bdcd_pkg::CntTwo |-> deadline_r == '0)
    else $error("double-click count with nonzero deadline");

  a_two_needs_latch: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == bdcd_pkg::CntTwo |-> latch_r)
    else $error("double-click count without press latch");

  a_idle_lane_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.take && active) |=> $stable(count_r) && $stable(latch_r))
    else $error("lane state moved without a transfer");

endmodule

// ===== hw/rtl/bdcd_merge.sv =====
// Merge stage: gathers lane results into masks and holds the output register.
// Depends on bdcd_pkg.
module bdcd_merge (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       take,
  input  bdcd_pkg::lane_res_t [bdcd_pkg::NumButtons-1:0] lane_res,
  output logic                                       room,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [bdcd_pkg::OutDataW-1:0]              out_tdata
);

  logic [bdcd_pkg::MaskBits-1:0] held;
  logic [bdcd_pkg::MaskBits-1:0] dbl;
  logic                          any;
  logic                          valid_r, valid_nxt;
  logic [bdcd_pkg::OutDataW-1:0] data_r;

  always_comb begin
    held = '0;
    dbl  = '0;
    for (int i = 0; i < bdcd_pkg::NumButtons; i++) begin
      if (i < bdcd_pkg::MaskBits) begin
        held[i] = lane_res[i].held;
        dbl[i]  = lane_res[i].dbl;
      end
    end
    any = |held;
  end

  // Accept when the register is empty or drains this cycle
  assign room      = !valid_r || out_tready;
  assign valid_nxt = take ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= {{(bdcd_pkg::OutDataW - 2 * bdcd_pkg::MaskBits - 1){1'b0}}, any, dbl, held};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  a_dbl_within_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2*bdcd_pkg::MaskBits-1:bdcd_pkg::MaskBits]
                    & ~out_tdata[bdcd_pkg::MaskBits-1:0]) == '0)
    else $error("double-click bit without held bit");

  a_any_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*bdcd_pkg::MaskBits] == (|out_tdata[bdcd_pkg::MaskBits-1:0]))
    else $error("any_pressed disagrees with held mask");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> valid_r)
    else $error("accepted sample did not reach output register");

endmodule

// ===== hw/rtl/button_double_click_detector.sv =====
// Top level of the button double-click detector: config registers, lanes, merge.
// Depends on bdcd_pkg, bdcd_lane and bdcd_merge.
//
// Usage:
//   in_*  : one transfer per sample. in_tdata = button_levels [15:0],
//           time_now [46:16], bit 47 zero.
//   out_* : one transfer per sample. out_tdata = held_mask [15:0],
//           double_click_mask [31:16], any_pressed [32], bits 39:33 zero.
//   cfg_* : APB-style register port. 0x0 double_click_window (8 bits, zero
//           acts as 1), 0x4 active_buttons (5 bits, values above 16 act as 16).
//           Write only while no sample is in flight.
// Sixteen lanes, one per button, evaluate a sample side by side in the cycle
// it is accepted and update their state at that edge; the merge stage
// registers the masks; out_tvalid rises in the cycle after the input transfer,
// and one sample is accepted every cycle while the receiver is ready: the single
// output register sets that figure. When the receiver stalls, the output register
// holds and in_tready drops until it drains. Reset clears every lane's latch,
// count and deadline, sets the window to 1 and the active count to 16, and
// empties the output register.
module button_double_click_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  // button_levels [15:0], time_now [46:16]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bdcd_pkg::InDataW-1:0]       in_tdata,
  // held_mask [15:0], double_click_mask [31:16], any_pressed [32]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bdcd_pkg::OutDataW-1:0]      out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bdcd_pkg::CfgAddrW-1:0]      cfg_paddr,
  input  logic [bdcd_pkg::CfgDataW-1:0]      cfg_pwdata,
  output logic [bdcd_pkg::CfgDataW-1:0]      cfg_prdata,
  output logic                               cfg_pready
);

  logic [bdcd_pkg::WinW-1:0]  window_r;
  logic [bdcd_pkg::ActW-1:0]  active_r;
  logic                       cfg_wr;
  bdcd_pkg::cfg_reg_t         cfg_sel;
  logic                       room;
  logic                       take;
  bdcd_pkg::lane_ctl_t        ctl;
  bdcd_pkg::lane_res_t [bdcd_pkg::NumButtons-1:0] lane_res;

  // Configuration port: zero-wait writes and reads
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = bdcd_pkg::cfg_reg_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= bdcd_pkg::WinReset;
      active_r <= bdcd_pkg::ActReset;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        bdcd_pkg::RegWindow: window_r <= cfg_pwdata[bdcd_pkg::WinW-1:0];
        bdcd_pkg::RegActive: active_r <= cfg_pwdata[bdcd_pkg::ActW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      bdcd_pkg::RegWindow:
        cfg_prdata = {{(bdcd_pkg::CfgDataW - bdcd_pkg::WinW){1'b0}}, window_r};
      bdcd_pkg::RegActive:
        cfg_prdata = {{(bdcd_pkg::CfgDataW - bdcd_pkg::ActW){1'b0}}, active_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  // Input handshake follows the output register
  assign in_tready = room;
  assign take      = in_tvalid && in_tready;

  // Broadcast control; a zero window acts as one tick
  assign ctl.take = take;
  assign ctl.now  = in_tdata[bdcd_pkg::LevelBits +: bdcd_pkg::TimeW];
  assign ctl.win  = (window_r == '0) ? bdcd_pkg::WinW'(1) : window_r;

  for (genvar g = 0; g < bdcd_pkg::NumButtons; g++) begin : g_lane
    logic level;
    logic active;

    // Buttons beyond the level field read as released
    if (g < bdcd_pkg::LevelBits) begin : g_lvl
      assign level = in_tdata[g];
    end else begin : g_nolvl
      assign level = 1'b0;
    end

    assign active = active_r > bdcd_pkg::ActW'(g);

    bdcd_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .active (active),
      .level  (level),
      .res    (lane_res[g])
    );
  end

  bdcd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .lane_res   (lane_res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !take)
    else $error("sample accepted while output register is stalled");

  a_cfg_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_sel == bdcd_pkg::RegActive |=> active_r == $past(cfg_pwdata[bdcd_pkg::ActW-1:0]))
    else $error("active_buttons write lost");

  a_zero_active_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    take && active_r == '0 |=> out_tdata[2*bdcd_pkg::MaskBits:0] == '0)
    else $error("output bits set with no active buttons");

endmodule

// ===== dv/button_double_click_detector_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for button_double_click_detector: stream in/out plus APB config.
// Depends on bdcd_pkg and the button_double_click_detector RTL; nothing else.
module button_double_click_detector_test;

  localparam int unsigned Limit       = 400000;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseItems  = 178;

  // One result as the block reports it
  typedef struct packed {
    logic [bdcd_pkg::MaskBits-1:0] held;
    logic [bdcd_pkg::MaskBits-1:0] dbl;
    logic                          any;
  } mask_set_t;

  // Tracks per-button click state and queues the masks each sample must produce.
  class double_click_scoreboard;
    logic                       latched [bdcd_pkg::NumButtons];
    bdcd_pkg::click_cnt_t       clicks  [bdcd_pkg::NumButtons];
    logic [bdcd_pkg::TimeW-1:0] deadline[bdcd_pkg::NumButtons];
    logic [bdcd_pkg::WinW-1:0]  window_reg;
    logic [bdcd_pkg::ActW-1:0]  active_reg;
    mask_set_t                  expected_masks[$];
    int unsigned                fail_count;

    function void clear();
      for (int i = 0; i < bdcd_pkg::NumButtons; i++) begin
        latched[i]  = 1'b0;
        clicks[i]   = bdcd_pkg::CntNone;
        deadline[i] = '0;
      end
      window_reg = bdcd_pkg::WinReset;
      active_reg = bdcd_pkg::ActReset;
      expected_masks.delete();
      fail_count = 0;
    endfunction

    function int unsigned pending();
      return expected_masks.size();
    endfunction

    function void note_sample(logic [bdcd_pkg::LevelBits-1:0] levels,
                              logic [bdcd_pkg::TimeW-1:0] now);
      mask_set_t   m;
      int unsigned n;
      logic [31:0] win;
      logic [31:0] sum;
      logic        flag;
      m   = '0;
      win = (window_reg == '0) ? 32'd1 : 32'(window_reg);
      n   = (active_reg > bdcd_pkg::NumButtons) ? bdcd_pkg::NumButtons : active_reg;
      for (int i = 0; i < n; i++) begin
        flag = 1'b0;
        if (levels[i]) begin
          m.any = 1'b1;
          if (!latched[i]) begin
            latched[i] = 1'b1;
            if (clicks[i] == bdcd_pkg::CntNone || now > deadline[i]) begin
              sum = {1'b0, now} + win;
              deadline[i] = (sum > {1'b0, bdcd_pkg::TimeMax}) ? bdcd_pkg::TimeMax
                                                               : sum[bdcd_pkg::TimeW-1:0];
              clicks[i] = bdcd_pkg::CntOne;
            end else if (now < deadline[i]) begin
              flag = 1'b1;
              deadline[i] = '0;
              clicks[i] = bdcd_pkg::CntTwo;
            end
          end else if (clicks[i] == bdcd_pkg::CntTwo) begin
            flag = 1'b1;
          end
        end else begin
          if (clicks[i] == bdcd_pkg::CntTwo) clicks[i] = bdcd_pkg::CntNone;
          latched[i] = 1'b0;
        end
        m.held[i] = levels[i];
        m.dbl[i]  = flag;
      end
      expected_masks.push_back(m);
    endfunction

    function void check_masks(logic [bdcd_pkg::OutDataW-1:0] data);
      mask_set_t want;
      mask_set_t got;
      got.held = data[15:0];
      got.dbl  = data[31:16];
      got.any  = data[32];
      if (expected_masks.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: held=%h dbl=%h any=%b", got.held, got.dbl, got.any);
        return;
      end
      want = expected_masks.pop_front();
      if (got != want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mask mismatch: expected held=%h dbl=%h any=%b, got held=%h dbl=%h any=%b",
                   want.held, want.dbl, want.any, got.held, got.dbl, got.any);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  // button_levels [15:0], time_now [46:16]
  logic [bdcd_pkg::InDataW-1:0]  in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  // held_mask [15:0], double_click_mask [31:16], any_pressed [32]
  logic [bdcd_pkg::OutDataW-1:0] out_tdata;
  logic                          cfg_psel = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite = 1'b0;
  logic [bdcd_pkg::CfgAddrW-1:0] cfg_paddr = '0;
  logic [bdcd_pkg::CfgDataW-1:0] cfg_pwdata = '0;
  logic [bdcd_pkg::CfgDataW-1:0] cfg_prdata;
  logic                          cfg_pready;

  double_click_scoreboard sb = new;
  int unsigned            cycle_count = 0;
  int unsigned            stall_left = 0;
  logic                   calm;

  button_double_click_detector dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // One window in four runs with no idling on either side
  assign calm = (cycle_count[9:8] == 2'b00);

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: stall out_tready at random
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 30) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: values read here are the ones present before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_sample(in_tdata[15:0], in_tdata[46:16]);
      if (out_tvalid && out_tready) sb.check_masks(out_tdata);
    end
  end

  // Hold valid low for a random gap, then offer one sample until it transfers.
  // Valid stays high afterwards so back-to-back samples need no extra edge.
  task automatic push_sample(input logic [bdcd_pkg::LevelBits-1:0] levels,
                             input logic [bdcd_pkg::TimeW-1:0] stamp);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, stamp, levels};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every expected result has been checked
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Setup cycle, access cycle, then drop the select; mirror the value in the predictor
  task automatic cfg_write(input bdcd_pkg::cfg_reg_t sel,
                           input logic [bdcd_pkg::CfgDataW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == bdcd_pkg::RegWindow) sb.window_reg = value[bdcd_pkg::WinW-1:0];
    else sb.active_reg = value[bdcd_pkg::ActW-1:0];
    @(posedge clk);
  endtask

  // Give up if the run hangs
  initial begin
    wait (cycle_count >= Limit);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [bdcd_pkg::CfgDataW-1:0]  win_set [PhaseCount];
    logic [bdcd_pkg::CfgDataW-1:0]  act_set [PhaseCount];
    logic [bdcd_pkg::LevelBits-1:0] levels;
    logic [31:0]                    t_cur;
    logic [31:0]                    step;
    int unsigned                    cur_win;
    int unsigned                    r;

    // Window zero acts as one; active counts of 0, 1, 16 and above 16 all appear
    win_set = '{32'd0, 32'd3, 32'd255, 32'd7, 32'd1, 32'd40, 32'd2, 32'd12};
    act_set = '{32'd0, 32'd16, 32'd31, 32'd1, 32'd16, 32'd9, 32'd17, 32'd16};

    sb.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings (window 1, all sixteen buttons)
    push_sample(16'h0000, 31'd0);
    push_sample(16'hFFFF, 31'd10);          // first press opens a window
    push_sample(16'h0000, 31'd10);
    push_sample(16'hFFFF, 31'd11);          // press exactly at the deadline: latch only
    push_sample(16'h0000, 31'd12);
    push_sample(16'hFFFF, 31'd12);          // past the deadline: new window
    push_sample(16'h0000, 31'd12);
    push_sample(16'hFFFF, 31'd12);          // inside the window: double click
    push_sample(16'hFFFF, 31'd13);          // flag holds while pressed
    push_sample(16'h5555, 31'd14);          // odd buttons release and clear their count
    push_sample(16'hAAAA, 31'd15);
    push_sample(16'h0000, 31'd16);
    push_sample(16'hAAAA, 31'd20);
    push_sample(16'h0000, 31'd5);           // time steps backwards
    push_sample(16'hFFFF, 31'd5);
    push_sample(16'h0000, bdcd_pkg::TimeMax);
    push_sample(16'hFFFF, bdcd_pkg::TimeMax);   // deadline saturates
    push_sample(16'h0000, bdcd_pkg::TimeMax);
    push_sample(16'hFFFF, bdcd_pkg::TimeMax);   // at the saturated deadline
    wait_for_results();
    repeat (2) @(posedge clk);

    // Widest window near the top of the time range
    cfg_write(bdcd_pkg::RegWindow, 32'd255);
    cfg_write(bdcd_pkg::RegActive, 32'd16);
    push_sample(16'h0000, 31'h7FFF_FF00);
    push_sample(16'h8001, 31'h7FFF_FF80);   // press inside the saturated window: double click
    push_sample(16'h0000, 31'h7FFF_FF90);
    push_sample(16'h8001, 31'h7FFF_FFA0);   // fresh press: saturating deadline, long window
    push_sample(16'h0000, 31'h7FFF_FFFF);
    wait_for_results();
    repeat (2) @(posedge clk);

    // Random phases, one register setting each
    levels = '0;
    for (int p = 0; p < PhaseCount; p++) begin
      cfg_write(bdcd_pkg::RegWindow, win_set[p]);
      cfg_write(bdcd_pkg::RegActive, act_set[p]);
      cur_win = (win_set[p][bdcd_pkg::WinW-1:0] == '0) ? 1 : win_set[p][bdcd_pkg::WinW-1:0];
      // Start one phase just below the top of the time range
      t_cur = (p == 2) ? 32'(bdcd_pkg::TimeMax) - 32'd400 : {1'b0, 31'($urandom())};
      for (int k = 0; k < PhaseItems; k++) begin
        // Let the pipeline run dry once mid-stream
        if (p == 4 && k == 90) wait_for_results();
        r = $urandom_range(0, 99);
        step = 0;
        if (r < 75) begin
          // Toggle a few buttons: presses, releases and re-presses
          levels = levels ^ (16'($urandom()) & 16'($urandom()) & 16'($urandom()));
          step = $urandom_range(0, cur_win + 2);
        end else if (r < 88) begin
          levels = 16'($urandom());
          step = $urandom_range(0, 3);
        end else if (r < 94) begin
          step = $urandom_range(cur_win + 3, 5000);
        end else if (r < 97) begin
          step = $urandom_range(1, 300);
          t_cur = (t_cur > step) ? t_cur - step : 32'd0;
          step = 0;
        end else begin
          t_cur = 32'(bdcd_pkg::TimeMax) - $urandom_range(0, 3);
          levels = 16'($urandom());
        end
        t_cur = t_cur + step;
        if (t_cur > 32'(bdcd_pkg::TimeMax)) t_cur = 32'(bdcd_pkg::TimeMax);
        push_sample(levels, t_cur[bdcd_pkg::TimeW-1:0]);
      end
      wait_for_results();
      repeat (2) @(posedge clk);
    end

    // Drain, then wait for any stray result
    wait_for_results();
    repeat (4) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
